@@ hw/rtl/phc_pkg.sv @@
// ----------------------------------------------------------------------------
// phc_pkg
// shared types, constants and the byte-wide crc-16 update for the header checker
// ----------------------------------------------------------------------------
package phc_pkg;

    localparam int HEADER_BYTES = 32;
    localparam int CRC_SPAN     = HEADER_BYTES - 2;
    localparam int COUNT_W      = 17;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [15:0]        CRC_INIT  = 16'hFFFF;
    localparam logic [15:0]        CRC_POLY  = 16'h1021;

    localparam int CFG_ADDR_W = 3;

    typedef enum logic [0:0] {
        REG_MAGIC   = 1'b0,
        REG_VERSION = 1'b1
    } phc_reg_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_CRC     = 2'd2,
        ST_VERSION = 2'd3
    } phc_status_t;

    typedef logic [HEADER_BYTES-1:0][7:0] phc_hdr_t;

    // view of a packet at its final byte, with that byte already folded in
    typedef struct packed {
        phc_hdr_t           hdr;
        logic [15:0]        crc;
        logic [COUNT_W-1:0] total;
    } phc_frame_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/packet_header_checker.sv @@
// ----------------------------------------------------------------------------
// packet_header_checker
// byte-stream packet header parser with crc-16 check and apb config registers
// ----------------------------------------------------------------------------
// the final byte passes through the input register, and its result is then held in the result register
// throughput: one byte per cycle when not stalled, set by the single-byte crc update stage
// a final byte holds in the input register while the result register is full
// reset: async active low; clears count, crc to 0xffff, valid flags, registers
// the header store has no reset; short packets report zero fields instead
module packet_header_checker
    import phc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic [31:0]           magic_word,
    output logic [7:0]            version_number,
    output logic [7:0]            mode_byte,
    output logic [7:0]            profile_byte,
    output logic [7:0]            flag_bits,
    output logic [31:0]           sequence_number,
    output logic [63:0]           sample_position,
    output logic [63:0]           capture_time,
    output logic [15:0]           payload_length,
    output logic [15:0]           header_check
);

    logic [31:0] magic_reg;
    logic [7:0]  version_reg;
    phc_reg_t    reg_sel;
    logic        wr_en;
    logic        slot_free;
    logic        done;
    phc_frame_t  frame;

    assign pready  = 1'b1;
    assign reg_sel = phc_reg_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= '0;
            version_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_MAGIC:   magic_reg   <= pwdata;
                REG_VERSION: version_reg <= pwdata[7:0];
                default:     magic_reg   <= magic_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_MAGIC:   prdata = magic_reg;
            REG_VERSION: prdata = {24'h000000, version_reg};
            default:     prdata = '0;
        endcase
    end

    phc_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .slot_free (slot_free),
        .done      (done),
        .frame     (frame)
    );

    phc_check u_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .done             (done),
        .frame            (frame),
        .expected_magic   (magic_reg),
        .expected_version (version_reg),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .slot_free        (slot_free),
        .status           (status),
        .magic_word       (magic_word),
        .version_number   (version_number),
        .mode_byte        (mode_byte),
        .profile_byte     (profile_byte),
        .flag_bits        (flag_bits),
        .sequence_number  (sequence_number),
        .sample_position  (sample_position),
        .capture_time     (capture_time),
        .payload_length   (payload_length),
        .header_check     (header_check)
    );

endmodule

@@ hw/rtl/phc_accum.sv @@
// ----------------------------------------------------------------------------
// phc_accum
// input register, byte count, running crc and header byte store
// ----------------------------------------------------------------------------
module phc_accum
    import phc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       slot_free,
    output logic       done,
    output phc_frame_t frame
);

    logic               in_valid_reg;
    logic [7:0]         in_data_reg;
    logic               in_last_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [15:0]        crc_reg;
    logic [15:0]        crc_next;
    logic [7:0]         store_reg [HEADER_BYTES];
    phc_hdr_t           hdr_next;
    logic               proc;
    logic               load;

    // a final byte waits until the result register can take its result
    assign proc     = in_valid_reg && (!in_last_reg || slot_free);
    assign in_ready = !in_valid_reg || proc;
    assign load     = in_valid && in_ready;
    assign done     = proc && in_last_reg;

    always_comb
    begin
        for (int i = 0; i < HEADER_BYTES; i++)
        begin
            if (count_reg == COUNT_W'(i))
                hdr_next[i] = in_data_reg;
            else
                hdr_next[i] = store_reg[i];
        end
        if (count_reg < COUNT_W'(CRC_SPAN))
            crc_next = crc16_byte(crc_reg, in_data_reg);
        else
            crc_next = crc_reg;
        if (count_reg != COUNT_MAX)
            count_next = count_reg + COUNT_W'(1);
        else
            count_next = count_reg;
    end

    assign frame.hdr   = hdr_next;
    assign frame.crc   = crc_next;
    assign frame.total = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            count_reg    <= '0;
            crc_reg      <= CRC_INIT;
        end
        else
        begin
            if (load)
                in_valid_reg <= 1'b1;
            else if (proc)
                in_valid_reg <= 1'b0;
            if (proc)
            begin
                if (in_last_reg)
                begin
                    count_reg <= '0;
                    crc_reg   <= CRC_INIT;
                end
                else
                begin
                    count_reg <= count_next;
                    crc_reg   <= crc_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_data_reg <= data_byte;
            in_last_reg <= last_byte;
        end
        if (proc)
        begin
            for (int i = 0; i < HEADER_BYTES; i++)
            begin
                store_reg[i] <= hdr_next[i];
            end
        end
    end

    a_end_of_packet_clears: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> count_reg == '0 && crc_reg == CRC_INIT)
        else $error("count or crc not restored after final word");

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        proc && !in_last_reg && count_reg != COUNT_MAX
        |=> count_reg == $past(count_reg) + COUNT_W'(1))
        else $error("byte count did not advance by one");

endmodule

@@ hw/rtl/phc_check.sv @@
// ----------------------------------------------------------------------------
// phc_check
// header field extraction, ordered checks and the result register
// ----------------------------------------------------------------------------
module phc_check
    import phc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        done,
    input  phc_frame_t  frame,
    input  logic [31:0] expected_magic,
    input  logic [7:0]  expected_version,
    input  logic        out_ready,
    output logic        out_valid,
    output logic        slot_free,
    output logic [1:0]  status,
    output logic [31:0] magic_word,
    output logic [7:0]  version_number,
    output logic [7:0]  mode_byte,
    output logic [7:0]  profile_byte,
    output logic [7:0]  flag_bits,
    output logic [31:0] sequence_number,
    output logic [63:0] sample_position,
    output logic [63:0] capture_time,
    output logic [15:0] payload_length,
    output logic [15:0] header_check
);

    logic        out_valid_reg;
    phc_hdr_t    hdr;
    logic        short_pkt;
    logic [COUNT_W-1:0] need;
    phc_status_t status_next;
    logic [1:0]  status_reg;
    logic [31:0] magic_reg;
    logic [7:0]  version_reg;
    logic [7:0]  mode_reg;
    logic [7:0]  profile_reg;
    logic [7:0]  flag_reg;
    logic [31:0] seq_reg;
    logic [63:0] sample_reg;
    logic [63:0] capture_reg;
    logic [15:0] plen_reg;
    logic [15:0] hcheck_reg;

    assign slot_free = !out_valid_reg || out_ready;
    assign short_pkt = frame.total < COUNT_W'(HEADER_BYTES);
    // short packets report all-zero header fields
    assign hdr       = short_pkt ? '0 : frame.hdr;
    assign need      = COUNT_W'(HEADER_BYTES) + COUNT_W'(hdr[29:28]);

    always_comb
    begin
        priority if (short_pkt)
            status_next = ST_INVALID;
        else if (hdr[31:30] != frame.crc)
            status_next = ST_CRC;
        else if (hdr[3:0] != expected_magic)
            status_next = ST_INVALID;
        else if (hdr[4] != expected_version)
            status_next = ST_VERSION;
        else if (frame.total < need)
            status_next = ST_INVALID;
        else
            status_next = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            status_reg  <= status_next;
            magic_reg   <= hdr[3:0];
            version_reg <= hdr[4];
            mode_reg    <= hdr[5];
            profile_reg <= hdr[6];
            flag_reg    <= hdr[7];
            seq_reg     <= hdr[11:8];
            sample_reg  <= hdr[19:12];
            capture_reg <= hdr[27:20];
            plen_reg    <= hdr[29:28];
            hcheck_reg  <= hdr[31:30];
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign magic_word      = magic_reg;
    assign version_number  = version_reg;
    assign mode_byte       = mode_reg;
    assign profile_byte    = profile_reg;
    assign flag_bits       = flag_reg;
    assign sequence_number = seq_reg;
    assign sample_position = sample_reg;
    assign capture_time    = capture_reg;
    assign payload_length  = plen_reg;
    assign header_check    = hcheck_reg;

    a_short_is_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        done && short_pkt |=> status_reg == ST_INVALID && magic_reg == '0
            && plen_reg == '0)
        else $error("short packet not reported as invalid with zero fields");

    a_ok_matches_config: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_OK
        |-> magic_reg == expected_magic && version_reg == expected_version
            && hcheck_reg != '0 || magic_reg == expected_magic
            && version_reg == expected_version)
        else $error("ok status on a header that fails magic or version");

    a_done_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> slot_free)
        else $error("result overwrote a word still waiting downstream");

endmodule

@@ tb/packet_header_checker_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packet_header_checker_test
// Self-checking bench: streams packets (runts, good headers, broken crc, magic,
// version and payload length) across several register settings,
// predicts every header result and compares it field by field.
// ----------------------------------------------------------------------------
module packet_header_checker_test;
    import phc_pkg::*;

    localparam int RUN_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES = 4;

    typedef enum int {
        PK_GOOD,
        PK_BAD_CRC,
        PK_BAD_MAGIC,
        PK_BAD_VERSION,
        PK_SHORT_PAYLOAD,
        PK_LONG_PAYLOAD,
        PK_RUNT
    } pkt_kind_t;

    typedef struct packed {
        phc_status_t status;
        logic [31:0] magic_word;
        logic [7:0]  version_number;
        logic [7:0]  mode_byte;
        logic [7:0]  profile_byte;
        logic [7:0]  flag_bits;
        logic [31:0] sequence_number;
        logic [63:0] sample_position;
        logic [63:0] capture_time;
        logic [15:0] payload_length;
        logic [15:0] header_check;
    } header_fields_t;

    class header_predictor;
        logic [31:0]        magic_reg;
        logic [7:0]         version_reg;
        logic [COUNT_W-1:0] count;
        logic [15:0]        crc;
        logic [7:0]         hdr [HEADER_BYTES];
        header_fields_t     expected_headers [$];
        int                 headers_predicted;
        int                 errors;

        function new();
            magic_reg         = '0;
            version_reg       = '0;
            count             = '0;
            crc               = CRC_INIT;
            headers_predicted = 0;
            errors            = 0;
        endfunction

        // msb-first crc-16, no reflection, no final xor
        static function logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
            logic [15:0] acc;
            int k;
            acc = c ^ {b, 8'h00};
            for (k = 0; k < 8; k++)
            begin
                acc = acc[15] ? ({acc[14:0], 1'b0} ^ CRC_POLY) : {acc[14:0], 1'b0};
            end
            return acc;
        endfunction

        function logic [63:0] le_bytes(input int at, input int n);
            logic [63:0] v;
            int i;
            v = '0;
            for (i = 0; i < n; i++)
            begin
                v[8*i +: 8] = hdr[at + i];
            end
            return v;
        endfunction

        function void take_byte(input logic [7:0] b, input logic last);
            header_fields_t r;
            if (count < HEADER_BYTES)
                hdr[count] = b;
            if (count < CRC_SPAN)
                crc = crc_step(crc, b);
            if (count != COUNT_MAX)
                count++;
            if (!last)
                return;
            r = '0;
            if (count < HEADER_BYTES)
            begin
                r.status = ST_INVALID;
            end
            else
            begin
                r.magic_word      = 32'(le_bytes(0, 4));
                r.version_number  = hdr[4];
                r.mode_byte       = hdr[5];
                r.profile_byte    = hdr[6];
                r.flag_bits       = hdr[7];
                r.sequence_number = 32'(le_bytes(8, 4));
                r.sample_position = le_bytes(12, 8);
                r.capture_time    = le_bytes(20, 8);
                r.payload_length  = 16'(le_bytes(28, 2));
                r.header_check    = 16'(le_bytes(30, 2));
                if (r.header_check != crc)
                    r.status = ST_CRC;
                else if (r.magic_word != magic_reg)
                    r.status = ST_INVALID;
                else if (r.version_number != version_reg)
                    r.status = ST_VERSION;
                else if (int'(count) < HEADER_BYTES + int'(r.payload_length))
                    r.status = ST_INVALID;
                else
                    r.status = ST_OK;
            end
            expected_headers.push_back(r);
            headers_predicted++;
            count = '0;
            crc   = CRC_INIT;
        endfunction

        function void compare_field(input string name, input logic [63:0] want,
                                    input logic [63:0] got);
            if (want !== got)
            begin
                $display("[%0t] %s mismatch: expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_header(input header_fields_t got);
            header_fields_t want;
            if (expected_headers.size() == 0)
            begin
                $display("[%0t] status mismatch: expected no word, actual %0h", $time,
                         got.status);
                errors++;
                return;
            end
            want = expected_headers.pop_front();
            compare_field("status",          64'(want.status),          64'(got.status));
            compare_field("magic_word",      64'(want.magic_word),      64'(got.magic_word));
            compare_field("version_number",  64'(want.version_number),
                          64'(got.version_number));
            compare_field("mode_byte",       64'(want.mode_byte),       64'(got.mode_byte));
            compare_field("profile_byte",    64'(want.profile_byte),    64'(got.profile_byte));
            compare_field("flag_bits",       64'(want.flag_bits),       64'(got.flag_bits));
            compare_field("sequence_number", 64'(want.sequence_number),
                          64'(got.sequence_number));
            compare_field("sample_position", want.sample_position,      got.sample_position);
            compare_field("capture_time",    want.capture_time,         got.capture_time);
            compare_field("payload_length",  64'(want.payload_length),
                          64'(got.payload_length));
            compare_field("header_check",    64'(want.header_check),    64'(got.header_check));
        endfunction

        function int pending();
            return expected_headers.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            data_byte;
    logic                  last_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            status;
    logic [31:0]           magic_word;
    logic [7:0]            version_number;
    logic [7:0]            mode_byte;
    logic [7:0]            profile_byte;
    logic [7:0]            flag_bits;
    logic [31:0]           sequence_number;
    logic [63:0]           sample_position;
    logic [63:0]           capture_time;
    logic [15:0]           payload_length;
    logic [15:0]           header_check;

    header_predictor predictor;
    logic [7:0]      pkt [$];
    bit              tx_calm;
    bit              rx_calm;
    int              items_sent;
    int              cycle_count;

    packet_header_checker u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .last_byte       (last_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .magic_word      (magic_word),
        .version_number  (version_number),
        .mode_byte       (mode_byte),
        .profile_byte    (profile_byte),
        .flag_bits       (flag_bits),
        .sequence_number (sequence_number),
        .sample_position (sample_position),
        .capture_time    (capture_time),
        .payload_length  (payload_length),
        .header_check    (header_check)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("packet_header_checker_test: FAIL");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        header_fields_t seen;
        if (rst_n && out_valid && out_ready)
        begin
            seen.status          = phc_status_t'(status);
            seen.magic_word      = magic_word;
            seen.version_number  = version_number;
            seen.mode_byte       = mode_byte;
            seen.profile_byte    = profile_byte;
            seen.flag_bits       = flag_bits;
            seen.sequence_number = sequence_number;
            seen.sample_position = sample_position;
            seen.capture_time    = capture_time;
            seen.payload_length  = payload_length;
            seen.header_check    = header_check;
            predictor.check_header(seen);
        end
    end

    // result side back-pressure
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            stall = rx_calm ? 0 : gap_len();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // plen doubles as the byte count of a runt
    function automatic void build_packet(input pkt_kind_t kind, input int plen,
                                         input int fill);
        logic [31:0] magic;
        logic [7:0]  ver;
        logic [15:0] crc;
        logic [15:0] len16;
        int          body;
        int          i;
        pkt.delete();
        if (kind == PK_RUNT)
        begin
            repeat (plen) pkt.push_back(8'($urandom));
            return;
        end
        if (kind == PK_SHORT_PAYLOAD && plen == 0)
            plen = 1;
        len16 = 16'(plen);
        magic = predictor.magic_reg;
        ver   = predictor.version_reg;
        if (kind == PK_BAD_MAGIC)
            magic ^= 32'(1) << $urandom_range(0, 31);
        if (kind == PK_BAD_VERSION)
            ver ^= 8'(1) << $urandom_range(0, 7);
        for (i = 0; i < 4; i++)
            pkt.push_back(magic[8*i +: 8]);
        pkt.push_back(ver);
        for (i = 5; i < 28; i++)
            pkt.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
        pkt.push_back(len16[7:0]);
        pkt.push_back(len16[15:8]);
        crc = CRC_INIT;
        for (i = 0; i < CRC_SPAN; i++)
            crc = header_predictor::crc_step(crc, pkt[i]);
        if (kind == PK_BAD_CRC)
            crc ^= 16'(1) << $urandom_range(0, 15);
        pkt.push_back(crc[7:0]);
        pkt.push_back(crc[15:8]);
        body = plen;
        if (kind == PK_SHORT_PAYLOAD)
            body = plen - $urandom_range(1, plen);
        if (kind == PK_LONG_PAYLOAD)
            body = plen + $urandom_range(1, 8);
        repeat (body) pkt.push_back(8'($urandom));
    endfunction

    task automatic send_packet();
        int g;
        int i;
        for (i = 0; i < pkt.size(); i++)
        begin
            in_valid  <= 1'b1;
            data_byte <= pkt[i];
            last_byte <= (i == pkt.size() - 1);
            do @(posedge clk); while (!in_ready);
            predictor.take_byte(pkt[i], i == pkt.size() - 1);
            items_sent++;
            g = tx_calm ? 0 : gap_len();
            if (g > 0)
            begin
                in_valid  <= 1'b0;
                data_byte <= 8'($urandom);
                last_byte <= 1'($urandom);
                repeat (g) @(posedge clk);
            end
        end
    endtask

    // stop sending and wait for every predicted header to come back
    task automatic settle();
        in_valid <= 1'b0;
        while (predictor.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input phc_reg_t which, input logic [31:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        readback = (which == REG_VERSION) ? {24'd0, value[7:0]} : value;
        if (prdata !== readback)
        begin
            $display("[%0t] register %s readback mismatch: expected %0h, actual %0h",
                     $time, which.name(), readback, prdata);
            predictor.errors++;
        end
        if (which == REG_MAGIC)
            predictor.magic_reg = value;
        else
            predictor.version_reg = value[7:0];
    endtask

    task automatic load_settings(input logic [31:0] magic, input logic [7:0] ver);
        settle();
        write_register(REG_MAGIC, magic);
        write_register(REG_VERSION, {24'd0, ver});
    endtask

    initial
    begin
        pkt_kind_t   kind;
        int          r;
        int          plen;
        int          ph;
        int          base_items;
        int          base_headers;
        logic [31:0] magic_pick;
        logic [7:0]  version_pick;

        predictor   = new();
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        data_byte   = '0;
        last_byte   = 1'b0;
        tx_calm     = 1'b1;
        rx_calm     = 1'b1;
        items_sent  = 0;
        cycle_count = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, registers at zero
        load_settings(32'h0, 8'h00);
        build_packet(PK_RUNT, 1, -1);              send_packet();
        build_packet(PK_RUNT, HEADER_BYTES - 1, -1); send_packet();
        build_packet(PK_GOOD, 0, 8'h00);           send_packet();
        build_packet(PK_BAD_CRC, 2, -1);           send_packet();
        build_packet(PK_BAD_MAGIC, 0, -1);         send_packet();
        build_packet(PK_BAD_VERSION, 0, -1);       send_packet();
        build_packet(PK_SHORT_PAYLOAD, 1, -1);     send_packet();
        build_packet(PK_GOOD, 3, -1);              send_packet();
        build_packet(PK_LONG_PAYLOAD, 0, -1);      send_packet();

        // directed, registers at all ones
        load_settings(32'hFFFF_FFFF, 8'hFF);
        build_packet(PK_GOOD, 0, 8'hFF);           send_packet();
        build_packet(PK_BAD_VERSION, 4, 8'hFF);    send_packet();
        build_packet(PK_GOOD, 64, 8'hFF);          send_packet();
        build_packet(PK_SHORT_PAYLOAD, 5, -1);     send_packet();
        build_packet(PK_GOOD, 1, -1);              send_packet();

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin magic_pick = $urandom;     version_pick = 8'($urandom); end
                1:       begin magic_pick = 32'h0;        version_pick = 8'hFF;        end
                2:       begin magic_pick = 32'hFFFF_FFFF; version_pick = 8'h00;       end
                default: begin magic_pick = $urandom;     version_pick = 8'($urandom); end
            endcase
            load_settings(magic_pick, version_pick);
            // one phase runs with no idling on either side
            tx_calm      = (ph == 2);
            rx_calm      = (ph == 2);
            base_items   = items_sent;
            base_headers = predictor.headers_predicted;
            while (items_sent - base_items < 180 ||
                   predictor.headers_predicted - base_headers < 3)
            begin
                r = $urandom_range(0, 99);
                if (r < 50)      kind = PK_GOOD;
                else if (r < 58) kind = PK_BAD_CRC;
                else if (r < 66) kind = PK_BAD_MAGIC;
                else if (r < 74) kind = PK_BAD_VERSION;
                else if (r < 82) kind = PK_SHORT_PAYLOAD;
                else if (r < 90) kind = PK_LONG_PAYLOAD;
                else             kind = PK_RUNT;
                plen = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 24)
                                                    : $urandom_range(25, 200);
                if (kind == PK_RUNT)
                    plen = $urandom_range(1, HEADER_BYTES - 1);
                build_packet(kind, plen, -1);
                send_packet();
                if ($urandom_range(0, 29) == 0)
                    settle();
            end
        end

        settle();
        if (predictor.errors == 0)
            $display("packet_header_checker_test: PASS");
        else
            $display("packet_header_checker_test: FAIL");
        $finish;
    end

endmodule
